/* hdl/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg - shared types and constants of the checksum frame parser
// Status codes, register indexes, frame descriptor, store write and result
// beat structures used by the front, the descriptor queue and the back.
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam int PAYLOAD_DEPTH   = 32;
   localparam int RESULT_LIMIT    = 32;
   localparam int MIN_FRAME_BYTES = 7;
   localparam int PAYLOAD_AW      = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int STORE_AW        = PAYLOAD_AW + 1;
   localparam int STORE_DEPTH     = 2 ** STORE_AW;
   localparam int LEN_CAP         = (PAYLOAD_DEPTH < RESULT_LIMIT) ? PAYLOAD_DEPTH
                                                                   : RESULT_LIMIT;
   localparam int POS_W           = 9;
   localparam logic [POS_W-1:0] POS_MAX = 9'd511;
   localparam int DESC_DEPTH      = 2;
   localparam int DESC_AW         = $clog2(DESC_DEPTH);
   localparam int OUT_DEPTH       = 4;
   localparam int OUT_AW          = $clog2(OUT_DEPTH);

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_SHORT      = 3'd1,
      STATUS_HEADER     = 3'd2,
      STATUS_LENGTH     = 3'd3,
      STATUS_INCOMPLETE = 3'd4,
      STATUS_TAIL       = 3'd5,
      STATUS_CHECKSUM   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      REG_HEADER_FIRST   = 3'd0,
      REG_HEADER_SECOND  = 3'd1,
      REG_TRAILER_FIRST  = 3'd2,
      REG_TRAILER_SECOND = 3'd3,
      REG_MAX_LENGTH     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] trailer_first;
      logic [7:0] trailer_second;
      logic [6:0] max_payload_length;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic [7:0] command;
      logic [6:0] length;
      logic       bank;
   } desc_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

   typedef struct packed {
      status_type status;
      logic [7:0] command;
      logic [6:0] payload_length;
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       last_result;
   } result_type;

endpackage

/* hdl/checksum_frame_parser.sv */
// ----------------------------------------------------------------------------
// checksum_frame_parser - header / length / checksum / tail frame parser
// Takes the bytes of a received buffer, checks header, length limit,
// completeness, tail and additive checksum, and returns a status beat or
// the payload bytes of a good frame.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ---------------------------------------
//  request   push / full           req_rx_byte, req_end_of_buffer
//  response  pop / empty           rsp_status, rsp_command,
//                                  rsp_payload_length, rsp_payload_byte,
//                                  rsp_payload_valid, rsp_last_result
//  csr       psel/penable/pwrite   paddr, pwdata, prdata, pready (always 1)
//
//  - one request beat per cycle; full rises only while both descriptor
//    queue entries (and so both payload store banks) are held by frames
//    that still have results to deliver
//  - the back issues one result per cycle through the registered store
//    read while the output queue has room; the first result reaches the
//    response ports via the descriptor queue, read stage and output queue
//  - reset clears all control state; the payload store has no reset and
//    needs no clearing pass
//  - a stalled response side fills the four-beat output queue, then the
//    back holds its descriptor; the front takes bytes until full rises
//
module checksum_frame_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_buffer,
   // response channel
   input  logic        pop,
   output logic        empty,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_command,
   output logic [6:0]  rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_last_result,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cfp_pkg::*;

   // config registers
   logic [7:0] header_first_ff;
   logic [7:0] header_second_ff;
   logic [7:0] trailer_first_ff;
   logic [7:0] trailer_second_ff;
   logic [6:0] max_len_ff;

   logic          csr_write;
   reg_index_type csr_index;
   cfg_type       cfg;

   logic          beat_accept;
   logic          desc_push;
   desc_type      desc;
   desc_type      head;
   logic          desc_full;
   logic          desc_empty;
   logic          desc_pop;
   store_wr_type  store_wr;
   result_type    result;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff   <= '0;
         header_second_ff  <= '0;
         trailer_first_ff  <= '0;
         trailer_second_ff <= '0;
         max_len_ff        <= 7'd32;
      end else if (csr_write) begin
         case (csr_index)
            REG_HEADER_FIRST:   header_first_ff   <= pwdata[7:0];
            REG_HEADER_SECOND:  header_second_ff  <= pwdata[7:0];
            REG_TRAILER_FIRST:  trailer_first_ff  <= pwdata[7:0];
            REG_TRAILER_SECOND: trailer_second_ff <= pwdata[7:0];
            REG_MAX_LENGTH:     max_len_ff        <= pwdata[6:0];
            default:            ; // unmapped address, write dropped
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_HEADER_FIRST:   prdata = {24'd0, header_first_ff};
         REG_HEADER_SECOND:  prdata = {24'd0, header_second_ff};
         REG_TRAILER_FIRST:  prdata = {24'd0, trailer_first_ff};
         REG_TRAILER_SECOND: prdata = {24'd0, trailer_second_ff};
         REG_MAX_LENGTH:     prdata = {25'd0, max_len_ff};
         default:            prdata = 32'd0;
      endcase
   end

   assign cfg.header_first       = header_first_ff;
   assign cfg.header_second      = header_second_ff;
   assign cfg.trailer_first      = trailer_first_ff;
   assign cfg.trailer_second     = trailer_second_ff;
   assign cfg.max_payload_length = max_len_ff;

   // request side stalls only when no store bank is free
   assign full        = desc_full;
   assign beat_accept = push && !full;

   cfp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .beat_accept   (beat_accept),
      .rx_byte       (req_rx_byte),
      .end_of_buffer (req_end_of_buffer),
      .desc_push     (desc_push),
      .desc          (desc),
      .store_wr      (store_wr)
   );

   cfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (desc),
      .full      (desc_full),
      .empty     (desc_empty),
      .head      (head),
      .pop       (desc_pop)
   );

   cfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .desc_empty (desc_empty),
      .head       (head),
      .desc_pop   (desc_pop),
      .pop        (pop),
      .empty      (empty),
      .result     (result)
   );

   // response fields straight from the output queue head
   assign rsp_status         = result.status;
   assign rsp_command        = result.command;
   assign rsp_payload_length = result.payload_length;
   assign rsp_payload_byte   = result.payload_byte;
   assign rsp_payload_valid  = result.payload_valid;
   assign rsp_last_result    = result.last_result;

endmodule

/* hdl/cfp_front.sv */
// ----------------------------------------------------------------------------
// cfp_front - byte front end of the checksum frame parser
// Tracks position, header, command, length, sums and tail of the current
// buffer, writes payload bytes to the store and issues one descriptor per
// buffer.
// ----------------------------------------------------------------------------
module cfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  cfp_pkg::cfg_type      cfg,
   input  logic                  beat_accept,
   input  logic [7:0]            rx_byte,
   input  logic                  end_of_buffer,
   output logic                  desc_push,
   output cfp_pkg::desc_type     desc,
   output cfp_pkg::store_wr_type store_wr
);
   import cfp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             hdr_ok_ff, hdr_ok_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       rsum_ff, rsum_in;
   logic [1:0]       tail_ff, tail_in;
   logic             bank_ff;

   logic [7:0] len_cur;
   logic [9:0] p_ext;
   logic [9:0] len_ext;
   logic [9:0] pay_idx;
   logic       in_payload;
   logic [6:0] limit;
   status_type status;

   always_comb begin
      len_cur   = (pos_ff == 9'd3) ? rx_byte : len_ff;
      p_ext     = {1'b0, pos_ff};
      len_ext   = {2'b00, len_cur};
      pay_idx   = p_ext - 10'd4;
      hdr_ok_in = hdr_ok_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      rsum_in   = rsum_ff;
      tail_in   = tail_ff;
      in_payload = 1'b0;

      if (pos_ff == 9'd0) begin
         hdr_ok_in = (rx_byte == cfg.header_first);
      end else if (pos_ff == 9'd1) begin
         hdr_ok_in = hdr_ok_ff && (rx_byte == cfg.header_second);
      end else if (pos_ff == 9'd2) begin
         cmd_in = rx_byte;
      end else if (pos_ff == 9'd3) begin
         len_in = rx_byte;
      end

      // header, command, length and payload all feed the checksum
      if (p_ext < 10'd4) begin
         sum_in = sum_ff + rx_byte;
      end else if (p_ext < 10'd4 + len_ext) begin
         sum_in     = sum_ff + rx_byte;
         in_payload = 1'b1;
      end else if (p_ext == 10'd4 + len_ext) begin
         rsum_in = rx_byte;
      end else if (p_ext == 10'd5 + len_ext) begin
         if (rx_byte == cfg.trailer_first) begin
            tail_in[0] = 1'b1;
         end
      end else if (p_ext == 10'd6 + len_ext) begin
         if (rx_byte == cfg.trailer_second) begin
            tail_in[1] = 1'b1;
         end
      end

      pos_in = (pos_ff < POS_MAX) ? pos_ff + 9'd1 : pos_ff;

      limit = (cfg.max_payload_length > 7'(LEN_CAP)) ? 7'(LEN_CAP)
                                                     : cfg.max_payload_length;

      if (pos_in < 9'(MIN_FRAME_BYTES)) begin
         status = STATUS_SHORT;
      end else if (!hdr_ok_in) begin
         status = STATUS_HEADER;
      end else if (len_cur > {1'b0, limit}) begin
         status = STATUS_LENGTH;
      end else if ({1'b0, pos_in} < 10'(MIN_FRAME_BYTES) + len_ext) begin
         status = STATUS_INCOMPLETE;
      end else if (tail_in != 2'b11) begin
         status = STATUS_TAIL;
      end else if (sum_in != rsum_in) begin
         status = STATUS_CHECKSUM;
      end else begin
         status = STATUS_OK;
      end

      desc_push    = beat_accept && end_of_buffer;
      desc.status  = status;
      desc.command = (status == STATUS_OK) ? cmd_in : 8'd0;
      desc.length  = (status == STATUS_OK) ? len_cur[6:0] : 7'd0;
      desc.bank    = bank_ff;

      store_wr.en   = beat_accept && in_payload && (pay_idx < 10'(PAYLOAD_DEPTH));
      store_wr.addr = {bank_ff, pay_idx[PAYLOAD_AW-1:0]};
      store_wr.data = rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hdr_ok_ff <= 1'b0;
         cmd_ff    <= '0;
         len_ff    <= '0;
         sum_ff    <= '0;
         rsum_ff   <= '0;
         tail_ff   <= '0;
         bank_ff   <= 1'b0;
      end else if (beat_accept) begin
         if (end_of_buffer) begin
            pos_ff    <= '0;
            hdr_ok_ff <= 1'b0;
            cmd_ff    <= '0;
            len_ff    <= '0;
            sum_ff    <= '0;
            rsum_ff   <= '0;
            tail_ff   <= '0;
            bank_ff   <= ~bank_ff;
         end else begin
            pos_ff    <= pos_in;
            hdr_ok_ff <= hdr_ok_in;
            cmd_ff    <= cmd_in;
            len_ff    <= len_in;
            sum_ff    <= sum_in;
            rsum_ff   <= rsum_in;
            tail_ff   <= tail_in;
         end
      end
   end

endmodule

/* hdl/cfp_queue.sv */
// ----------------------------------------------------------------------------
// cfp_queue - frame descriptor queue
// Short queue between front and back; an entry stays until the back has
// issued the last result of its frame, so the entry count is the number of
// store banks held.
// ----------------------------------------------------------------------------
module cfp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cfp_pkg::desc_type  push_desc,
   output logic               full,
   output logic               empty,
   output cfp_pkg::desc_type  head,
   input  logic               pop
);
   import cfp_pkg::*;

   desc_type           entry_ff [DESC_DEPTH];
   logic [DESC_AW-1:0] wr_ptr_ff;
   logic [DESC_AW-1:0] rd_ptr_ff;
   logic [DESC_AW:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == (DESC_AW+1)'(DESC_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == DESC_AW'(DESC_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == DESC_AW'(DESC_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* hdl/cfp_back.sv */
// ----------------------------------------------------------------------------
// cfp_back - result back end of the checksum frame parser
// Holds the two-bank payload store, walks the head descriptor one result
// per cycle, while the output queue has room, through a registered store
// read and buffers result beats in a small output queue.
// ----------------------------------------------------------------------------
module cfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cfp_pkg::store_wr_type store_wr,
   input  logic                  desc_empty,
   input  cfp_pkg::desc_type     head,
   output logic                  desc_pop,
   input  logic                  pop,
   output logic                  empty,
   output cfp_pkg::result_type   result
);
   import cfp_pkg::*;

   logic [7:0]    store_mem [STORE_DEPTH];
   logic [7:0]    rd_data_ff;

   logic [6:0]    idx_ff, idx_in;
   logic          p1_valid_ff;
   result_type    p1_meta_ff;
   result_type    meta;
   result_type    push_res;

   result_type    out_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] owr_ptr_ff;
   logic [OUT_AW-1:0] ord_ptr_ff;
   logic [OUT_AW:0]   ocount_ff;

   logic          single;
   logic          last_beat;
   logic          issue;
   logic          out_pop;
   logic [STORE_AW-1:0] rd_addr;

   always_comb begin
      single    = (head.status != STATUS_OK) || (head.length == 7'd0);
      last_beat = single || (idx_ff + 7'd1 == head.length);
      // credit: buffered beats plus the one in the read stage
      issue     = !desc_empty &&
                  (({1'b0, ocount_ff} + {{(OUT_AW+1){1'b0}}, p1_valid_ff}) <
                   (OUT_AW+2)'(OUT_DEPTH));
      desc_pop  = issue && last_beat;
      idx_in    = issue ? (last_beat ? 7'd0 : idx_ff + 7'd1) : idx_ff;
      rd_addr   = {head.bank, idx_ff[PAYLOAD_AW-1:0]};

      meta.status         = head.status;
      meta.command        = head.command;
      meta.payload_length = head.length;
      meta.payload_byte   = 8'd0;
      meta.payload_valid  = !single;
      meta.last_result    = last_beat;

      push_res              = p1_meta_ff;
      push_res.payload_byte = p1_meta_ff.payload_valid ? rd_data_ff : 8'd0;

      empty   = (ocount_ff == '0);
      out_pop = pop && !empty;
      result  = out_ff[ord_ptr_ff];
   end

   // payload store: front writes the free bank, back reads the held one
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      if (issue) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p1_meta_ff <= meta;
      end
      if (p1_valid_ff) begin
         out_ff[owr_ptr_ff] <= push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         p1_valid_ff <= 1'b0;
         owr_ptr_ff  <= '0;
         ord_ptr_ff  <= '0;
         ocount_ff   <= '0;
      end else begin
         idx_ff      <= idx_in;
         p1_valid_ff <= issue;
         if (p1_valid_ff) begin
            owr_ptr_ff <= owr_ptr_ff + 1'b1;
         end
         if (out_pop) begin
            ord_ptr_ff <= ord_ptr_ff + 1'b1;
         end
         case ({p1_valid_ff, out_pop})
            2'b10:   ocount_ff <= ocount_ff + 1'b1;
            2'b01:   ocount_ff <= ocount_ff - 1'b1;
            default: ocount_ff <= ocount_ff;
         endcase
      end
   end

endmodule

/* tb/cfp_result_checker.sv */
// ----------------------------------------------------------------------------
// cfp_result_checker - response predictor and scoreboard for the frame parser
// Watches the csr, request and response channels, keeps its own copy of the
// parser registers and per-buffer state, queues the beats each buffer should
// produce and compares every popped beat field by field against the oldest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_buffer,
   input  logic        pop,
   input  logic        empty,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_command,
   input  logic [6:0]  rsp_payload_length,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_payload_valid,
   input  logic        rsp_last_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fault_count,
   output int          beats_pending
);
   import cfp_pkg::*;

   // register shadow
   logic [7:0]       hdr_first_cfg;
   logic [7:0]       hdr_second_cfg;
   logic [7:0]       tail_first_cfg;
   logic [7:0]       tail_second_cfg;
   logic [6:0]       max_len_cfg;

   // per-buffer parse state
   logic [POS_W-1:0] byte_count;
   logic             hdr_ok;
   logic [7:0]       cmd_byte;
   logic [7:0]       len_byte;
   logic [7:0]       sum_running;
   logic [7:0]       sum_received;
   logic [1:0]       tail_ok;
   logic [7:0]       payload_copy [PAYLOAD_DEPTH];

   result_type       expected_beats [$];

   function automatic void clear_frame();
      byte_count   = '0;
      hdr_ok       = 1'b0;
      cmd_byte     = '0;
      len_byte     = '0;
      sum_running  = '0;
      sum_received = '0;
      tail_ok      = '0;
   endfunction

   // one buffer byte in; on the final byte, the beats it causes are queued
   function automatic void absorb_byte(input logic [7:0] b, input logic last);
      int         p;
      int         len;
      int         lim;
      int         cnt;
      status_type st;
      result_type r;
      p = byte_count;
      case (p)
         0: hdr_ok = (b == hdr_first_cfg);
         1: hdr_ok = hdr_ok && (b == hdr_second_cfg);
         2: cmd_byte = b;
         3: len_byte = b;
         default: ;
      endcase
      len = len_byte;
      if (p < 4) begin
         sum_running = sum_running + b;
      end else if (p < 4 + len) begin
         sum_running = sum_running + b;
         if (p - 4 < PAYLOAD_DEPTH) payload_copy[p - 4] = b;
      end else if (p == 4 + len) begin
         sum_received = b;
      end else if (p == 5 + len) begin
         if (b == tail_first_cfg) tail_ok[0] = 1'b1;
      end else if (p == 6 + len) begin
         if (b == tail_second_cfg) tail_ok[1] = 1'b1;
      end
      if (byte_count < POS_MAX) byte_count = byte_count + 1'b1;
      if (!last) return;

      cnt = byte_count;
      lim = max_len_cfg;
      if (lim > PAYLOAD_DEPTH) lim = PAYLOAD_DEPTH;
      if (lim > RESULT_LIMIT) lim = RESULT_LIMIT;
      if (cnt < MIN_FRAME_BYTES)            st = STATUS_SHORT;
      else if (!hdr_ok)                     st = STATUS_HEADER;
      else if (len > lim)                   st = STATUS_LENGTH;
      else if (cnt < MIN_FRAME_BYTES + len) st = STATUS_INCOMPLETE;
      else if (tail_ok != 2'b11)            st = STATUS_TAIL;
      else if (sum_running != sum_received) st = STATUS_CHECKSUM;
      else                                  st = STATUS_OK;

      if (st != STATUS_OK || len == 0) begin
         r = '0;
         r.status = st;
         if (st == STATUS_OK) r.command = cmd_byte;
         r.last_result = 1'b1;
         expected_beats.push_back(r);
      end else begin
         for (int i = 0; i < len && i < PAYLOAD_DEPTH && i < RESULT_LIMIT; i++) begin
            r.status         = STATUS_OK;
            r.command        = cmd_byte;
            r.payload_length = len[6:0];
            r.payload_byte   = payload_copy[i];
            r.payload_valid  = 1'b1;
            r.last_result    = (i + 1 == len);
            expected_beats.push_back(r);
         end
      end
      clear_frame();
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         hdr_first_cfg   = '0;
         hdr_second_cfg  = '0;
         tail_first_cfg  = '0;
         tail_second_cfg = '0;
         max_len_cfg     = 7'd32;
         fault_count     = 0;
         clear_frame();
         expected_beats.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_HEADER_FIRST:   hdr_first_cfg   = pwdata[7:0];
               REG_HEADER_SECOND:  hdr_second_cfg  = pwdata[7:0];
               REG_TRAILER_FIRST:  tail_first_cfg  = pwdata[7:0];
               REG_TRAILER_SECOND: tail_second_cfg = pwdata[7:0];
               REG_MAX_LENGTH:     max_len_cfg     = pwdata[6:0];
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (expected_beats.size() == 0) begin
               $error("response beat with nothing expected");
               fault_count++;
            end else begin
               want = expected_beats.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("command", want.command, rsp_command);
               check_field("payload_length", want.payload_length, rsp_payload_length);
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("payload_valid", want.payload_valid, rsp_payload_valid);
               check_field("last_result", want.last_result, rsp_last_result);
            end
         end
         if (push && !full) absorb_byte(req_rx_byte, req_end_of_buffer);
      end
      beats_pending = expected_beats.size();
   end

endmodule

/* tb/checksum_frame_parser_test.sv */
// ----------------------------------------------------------------------------
// checksum_frame_parser_test - top level testbench of the frame parser
// Programs header, tail and length limit registers over the csr port, sends
// directed buffers for every status and corner, then random buffers under
// several register settings with bursty input and a stalling receiver. The
// checker beside the block predicts and compares all response beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checksum_frame_parser_test;
   import cfp_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int RANDOM_BEATS    = 32;
   localparam int RANDOM_PHASES   = 4;
   localparam int SETTLE_CYCLES   = 12;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam logic [4:0] UNMAPPED_ADDR = 5'd20;

   // ways a generated frame can be spoiled
   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER_FIRST,
      FLAW_HEADER_SECOND,
      FLAW_LENGTH,
      FLAW_CHECKSUM,
      FLAW_TAIL_FIRST,
      FLAW_TAIL_SECOND
   } flaw_type;

   typedef logic [7:0] octet_q_type [$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = '0;
   logic        req_end_of_buffer = 1'b0;
   logic        pop = 1'b0;
   logic        empty;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_command;
   logic [6:0]  rsp_payload_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_valid;
   logic        rsp_last_result;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int          fault_count;
   int          beats_pending;
   int          cycle_count = 0;
   int          burst_left = 0;
   logic        hold_off_armed = 1'b0;
   logic        hold_off_taken = 1'b0;

   // stimulus-side view of the registers, used to build matching frames
   logic [7:0]  frame_hdr_first = '0;
   logic [7:0]  frame_hdr_second = '0;
   logic [7:0]  frame_tail_first = '0;
   logic [7:0]  frame_tail_second = '0;
   logic [6:0]  frame_max_len = 7'd32;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   checksum_frame_parser u_dut (.*);

   cfp_result_checker u_checker (.*);

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: pop duty cycle changes after each random span; one long
   // hold-off lets the output side back up until full rises at the input
   initial begin : receiver
      int pct;
      int span;
      forever begin
         span = $urandom_range(8, 64);
         case ($urandom_range(0, 3))
            0:       pct = 100;
            1:       pct = 75;
            2:       pct = 40;
            default: pct = 15;
         endcase
         repeat (span) begin
            @(negedge clock);
            if (hold_off_armed && !hold_off_taken) begin
               hold_off_taken = 1'b1;
               pop = 1'b0;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
            end
            pop = ($urandom_range(1, 100) <= pct);
         end
      end
   end

   // payload limit the parser applies at the end of a buffer
   function automatic int length_limit();
      int lim;
      lim = frame_max_len;
      if (lim > PAYLOAD_DEPTH) lim = PAYLOAD_DEPTH;
      if (lim > RESULT_LIMIT) lim = RESULT_LIMIT;
      return lim;
   endfunction

   // two-phase csr write, setup then access
   task automatic write_csr(input logic [4:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      case (addr[4:2])
         REG_HEADER_FIRST:   frame_hdr_first   = data[7:0];
         REG_HEADER_SECOND:  frame_hdr_second  = data[7:0];
         REG_TRAILER_FIRST:  frame_tail_first  = data[7:0];
         REG_TRAILER_SECOND: frame_tail_second = data[7:0];
         REG_MAX_LENGTH:     frame_max_len     = data[6:0];
         default: ;
      endcase
   endtask

   task automatic write_frame_regs(input logic [7:0] h1, input logic [7:0] h2,
                                   input logic [7:0] t1, input logic [7:0] t2,
                                   input logic [31:0] max_len);
      write_csr({REG_HEADER_FIRST, 2'b00}, {24'd0, h1});
      write_csr({REG_HEADER_SECOND, 2'b00}, {24'd0, h2});
      write_csr({REG_TRAILER_FIRST, 2'b00}, {24'd0, t1});
      write_csr({REG_TRAILER_SECOND, 2'b00}, {24'd0, t2});
      write_csr({REG_MAX_LENGTH, 2'b00}, max_len);
   endtask

   // quiet the input and wait until every expected beat has come back
   task automatic settle();
      push = 1'b0;
      @(negedge clock);
      while (beats_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one request beat; bursts of random length separated by random gaps,
   // with some bursts following straight on for gap-free stretches
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            push = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push              = 1'b1;
      req_rx_byte       = b;
      req_end_of_buffer = last;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_buffer(input octet_q_type octets);
      foreach (octets[i]) send_byte(octets[i], i == octets.size() - 1);
   endtask

   // header, command, length, payload, checksum, tail, then trailing bytes;
   // a nonzero cut keeps only that many leading bytes
   function automatic octet_q_type build_frame(input logic [7:0] cmd, input int len,
                                               input flaw_type flaw, input int cut,
                                               input int extra);
      octet_q_type f;
      logic [7:0]  sum;
      f = {frame_hdr_first, frame_hdr_second, cmd, len[7:0]};
      if (flaw == FLAW_LENGTH) begin
         // declared length too big: a short random body is enough
         repeat ($urandom_range(3, 10)) f.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (len) f.push_back(8'($urandom_range(0, 255)));
         sum = '0;
         foreach (f[i]) sum += f[i];
         f.push_back(sum);
         f.push_back(frame_tail_first);
         f.push_back(frame_tail_second);
         case (flaw)
            FLAW_HEADER_FIRST:  f[0] ^= 8'($urandom_range(1, 255));
            FLAW_HEADER_SECOND: f[1] ^= 8'($urandom_range(1, 255));
            FLAW_CHECKSUM:      f[4 + len] ^= 8'($urandom_range(1, 255));
            FLAW_TAIL_FIRST:    f[5 + len] ^= 8'($urandom_range(1, 255));
            FLAW_TAIL_SECOND:   f[6 + len] ^= 8'($urandom_range(1, 255));
            default: ;
         endcase
      end
      repeat (extra) f.push_back(8'($urandom_range(0, 255)));
      if (cut > 0 && cut < f.size()) f = f[0:cut-1];
      return f;
   endfunction

   task automatic send_frame(input logic [7:0] cmd, input int len, input flaw_type flaw,
                             input int cut, input int extra);
      send_buffer(build_frame(cmd, len, flaw, cut, extra));
   endtask

   // mostly well-formed frames with random content, the rest spoiled,
   // truncated or plain noise
   task automatic send_random_buffer(inout int beats);
      octet_q_type octets;
      int          kind;
      int          lim;
      int          len;
      int          extra;
      flaw_type    flaw;
      lim   = length_limit();
      kind  = $urandom_range(0, 99);
      extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      len   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim)
                                          : $urandom_range(0, (lim < 8) ? lim : 8);
      if (kind < 65) begin
         octets = build_frame(8'($urandom_range(0, 255)), len, FLAW_NONE, 0, extra);
      end else if (kind < 88) begin
         flaw = flaw_type'($urandom_range(FLAW_HEADER_FIRST, FLAW_TAIL_SECOND));
         if (flaw == FLAW_LENGTH) len = $urandom_range(lim + 1, 255);
         octets = build_frame(8'($urandom_range(0, 255)), len, flaw, 0, extra);
      end else if (kind < 94) begin
         octets = build_frame(8'($urandom_range(0, 255)), len, FLAW_NONE, 0, 0);
         octets = octets[0:$urandom_range(0, octets.size() - 2)];
      end else begin
         repeat ($urandom_range(1, 12)) octets.push_back(8'($urandom_range(0, 255)));
      end
      send_buffer(octets);
      beats += octets.size();
   endtask

   initial begin : stimulus
      int phase_beats;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // long receiver hold-off while the directed frames keep coming
      hold_off_armed = 1'b1;

      // directed: every status, empty and full payloads, trailing bytes
      write_frame_regs(8'hA5, 8'h5A, 8'h0D, 8'h0A, 32'd32);
      send_frame(8'h00, 0, FLAW_NONE, 0, 0);            // empty payload
      send_frame(8'hFF, 3, FLAW_NONE, 0, 0);
      send_frame(8'h3C, 32, FLAW_NONE, 0, 0);           // payload at the limit
      send_frame(8'h11, 4, FLAW_NONE, 1, 0);            // one-byte buffer
      send_frame(8'h11, 4, FLAW_NONE, 6, 0);            // one byte short of minimum
      send_frame(8'h22, 2, FLAW_HEADER_FIRST, 0, 0);
      send_frame(8'h22, 2, FLAW_HEADER_SECOND, 0, 0);
      send_frame(8'h33, 33, FLAW_LENGTH, 0, 0);          // just over the limit
      send_frame(8'h33, 255, FLAW_LENGTH, 0, 0);
      send_frame(8'h44, 5, FLAW_NONE, 9, 0);            // incomplete frame, cut after the payload
      send_frame(8'h55, 1, FLAW_TAIL_FIRST, 0, 0);
      send_frame(8'h55, 1, FLAW_TAIL_SECOND, 0, 0);
      send_frame(8'h66, 6, FLAW_CHECKSUM, 0, 0);
      send_frame(8'h77, 2, FLAW_NONE, 0, 3);            // bytes after the tail
      settle();

      // opposite register extremes, zero payload limit
      write_frame_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 32'd0);
      send_frame(8'h99, 0, FLAW_NONE, 0, 0);
      send_frame(8'h99, 1, FLAW_NONE, 0, 0);            // over a zero limit
      settle();

      // limit register all ones: masked to 127, clamped to the store depth;
      // a write past the last register must change nothing
      write_csr({REG_MAX_LENGTH, 2'b00}, 32'hFFFF_FFFF);
      write_csr(UNMAPPED_ADDR, 32'hFFFF_FFFF);
      send_frame(8'hAA, 32, FLAW_NONE, 0, 0);
      send_frame(8'hAA, 33, FLAW_LENGTH, 0, 0);
      settle();

      // random buffers under a few register settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       write_frame_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), $urandom_range(1, 32));
            1:       write_frame_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), 32'd64);
            2:       write_frame_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), $urandom);
            default: write_frame_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), $urandom_range(8, 32));
         endcase
         phase_beats = 0;
         while (phase_beats < RANDOM_BEATS / RANDOM_PHASES) send_random_buffer(phase_beats);
         settle();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
